// ----- rtl/ddsp_pkg.sv -----
// shared types and constants for the dotted date string parser
package ddsp_pkg;

	localparam int unsigned CharWidth    = 8;
	localparam int unsigned ValueWidth   = 16;
	localparam int unsigned MonthWidth   = 4;
	localparam int unsigned DayWidth     = 5;
	localparam int unsigned ApbAddrWidth = 3;
	localparam int unsigned ApbDataWidth = 32;
	localparam int unsigned InDataWidth  = 8;
	localparam int unsigned OutDataWidth = 32;

	localparam logic [CharWidth-1:0] CharNul      = 8'h00;
	localparam logic [CharWidth-1:0] CharDot      = 8'h2e;
	localparam logic [CharWidth-1:0] CharQuestion = 8'h3f;
	localparam logic [CharWidth-1:0] CharZero     = 8'h30;
	localparam logic [CharWidth-1:0] CharNine     = 8'h39;

	localparam logic [ValueWidth-1:0] YearLimitReset = 16'd2047;
	localparam logic [ValueWidth-1:0] MonthLimit     = 16'd12;
	localparam logic [ValueWidth-1:0] DayLimit       = 16'd31;
	localparam logic [ValueWidth-1:0] ValueMax       = 16'hffff;
	localparam logic [ValueWidth-1:0] MonthSatWide   = 16'd15;
	localparam logic [MonthWidth-1:0] MonthSat       = 4'd15;
	localparam logic [MonthWidth-1:0] MonthMax       = 4'd12;

	// register index taken from paddr above the byte offset
	localparam logic RegYearLimit = 1'b0;

	typedef enum logic [1:0] {
		FIELD_YEAR,
		FIELD_MONTH,
		FIELD_DAY,
		FIELD_EXTRA
	} field_t;

	typedef struct packed {
		logic                  text_valid;
		logic [DayWidth-1:0]   day_value;
		logic [MonthWidth-1:0] month_value;
		logic [ValueWidth-1:0] year_value;
	} result_t;

	localparam int unsigned ResultWidth = $bits(result_t);

endpackage

// ----- rtl/ddsp_apb_regs.sv -----
// apb configuration register holding the year limit
module ddsp_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ddsp_pkg::ApbAddrWidth-1:0]   paddr,
	input  logic [ddsp_pkg::ApbDataWidth-1:0]   pwdata,
	output logic [ddsp_pkg::ApbDataWidth-1:0]   prdata,
	output logic                                pready,
	output logic [ddsp_pkg::ValueWidth-1:0]     year_limit
);
	import ddsp_pkg::*;

	logic                  reg_index;
	logic                  wr_en;
	logic [ValueWidth-1:0] year_limit_q;

	assign pready    = 1'b1;
	assign reg_index = paddr[ApbAddrWidth-1];
	assign wr_en     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_limit_q <= YearLimitReset;
		end else if (wr_en && (reg_index == RegYearLimit)) begin
			year_limit_q <= pwdata[ValueWidth-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_index == RegYearLimit) begin
			prdata = {{(ApbDataWidth-ValueWidth){1'b0}}, year_limit_q};
		end
	end

	assign year_limit = year_limit_q;

endmodule

// ----- rtl/ddsp_parser.sv -----
// per-character parse state and end-of-text result logic
module ddsp_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            char_valid,
	input  logic [ddsp_pkg::CharWidth-1:0]  text_char,
	input  logic [ddsp_pkg::ValueWidth-1:0] year_limit,
	output logic                            result_fire,
	output ddsp_pkg::result_t               result
);
	import ddsp_pkg::*;

	field_t                field_q, field_d;
	logic [ValueWidth-1:0] acc_q, acc_d;
	logic                  open_q, open_d;
	logic                  saw_digit_q, saw_digit_d;
	logic                  saw_question_q, saw_question_d;
	logic                  saw_other_q, saw_other_d;
	logic                  sticky_q, sticky_d;
	logic [ValueWidth-1:0] held_year_q, held_year_d;
	logic [MonthWidth-1:0] held_month_q, held_month_d;

	logic [ValueWidth-1:0] field_limit;
	logic                  field_bad;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [ValueWidth+3:0] acc_x10;
	logic [ValueWidth+3:0] acc_sum;
	logic [ValueWidth-1:0] acc_next;
	logic [MonthWidth-1:0] month_sat;
	logic [ValueWidth-1:0] year_ok;
	logic [ValueWidth-1:0] res_year;
	logic [MonthWidth-1:0] res_month;
	logic [ValueWidth-1:0] res_day;

	always_comb begin
		unique case (field_q)
			FIELD_YEAR:  field_limit = year_limit;
			FIELD_MONTH: field_limit = MonthLimit;
			default:     field_limit = DayLimit;
		endcase
		field_bad = saw_other_q || (saw_question_q && saw_digit_q) ||
			(saw_digit_q && (acc_q > field_limit));
		is_digit  = (text_char >= CharZero) && (text_char <= CharNine);
		digit     = 4'(text_char - CharZero);
		acc_x10   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		acc_sum   = acc_x10 + {{ValueWidth{1'b0}}, digit};
		acc_next  = (acc_sum > {4'h0, ValueMax}) ? ValueMax : acc_sum[ValueWidth-1:0];
		month_sat = (acc_q > MonthSatWide) ? MonthSat : acc_q[MonthWidth-1:0];
		year_ok   = (acc_q > year_limit) ? '0 : acc_q;
	end

	// result seen at the terminating nul
	always_comb begin
		res_year  = held_year_q;
		res_month = '0;
		res_day   = '0;
		unique case (field_q)
			FIELD_YEAR: begin
				res_year = year_ok;
			end
			FIELD_MONTH: begin
				res_month = month_sat;
			end
			FIELD_DAY, FIELD_EXTRA: begin
				res_month = held_month_q;
				res_day   = acc_q;
			end
		endcase
		if (res_month > MonthMax) begin
			res_month = '0;
			res_day   = '0;
		end
		if (res_day > DayLimit) begin
			res_day = '0;
		end
		result.year_value  = res_year;
		result.month_value = res_month;
		result.day_value   = res_day[DayWidth-1:0];
		result.text_valid  = !(sticky_q || ((field_q != FIELD_EXTRA) && field_bad));
	end

	always_comb begin
		field_d        = field_q;
		acc_d          = acc_q;
		open_d         = open_q;
		saw_digit_d    = saw_digit_q;
		saw_question_d = saw_question_q;
		saw_other_d    = saw_other_q;
		sticky_d       = sticky_q;
		held_year_d    = held_year_q;
		held_month_d   = held_month_q;
		result_fire    = 1'b0;
		if (char_valid) begin
			if (text_char == CharNul) begin
				result_fire    = 1'b1;
				field_d        = FIELD_YEAR;
				acc_d          = '0;
				open_d         = 1'b1;
				saw_digit_d    = 1'b0;
				saw_question_d = 1'b0;
				saw_other_d    = 1'b0;
				sticky_d       = 1'b0;
				held_year_d    = '0;
				held_month_d   = '0;
			end else if (field_q != FIELD_EXTRA) begin
				if (text_char == CharDot) begin
					sticky_d = sticky_q || field_bad;
					if (field_q == FIELD_DAY) begin
						sticky_d = 1'b1;
						field_d  = FIELD_EXTRA;
					end else begin
						if (field_q == FIELD_YEAR) begin
							held_year_d = year_ok;
							field_d     = FIELD_MONTH;
						end else begin
							held_month_d = month_sat;
							field_d      = FIELD_DAY;
						end
						acc_d          = '0;
						open_d         = 1'b1;
						saw_digit_d    = 1'b0;
						saw_question_d = 1'b0;
						saw_other_d    = 1'b0;
					end
				end else if (is_digit) begin
					saw_digit_d = 1'b1;
					if (open_q) begin
						acc_d = acc_next;
					end
				end else if (text_char == CharQuestion) begin
					saw_question_d = 1'b1;
					open_d         = 1'b0;
				end else begin
					saw_other_d = 1'b1;
					open_d      = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q        <= FIELD_YEAR;
			acc_q          <= '0;
			open_q         <= 1'b1;
			saw_digit_q    <= 1'b0;
			saw_question_q <= 1'b0;
			saw_other_q    <= 1'b0;
			sticky_q       <= 1'b0;
			held_year_q    <= '0;
			held_month_q   <= '0;
		end else begin
			field_q        <= field_d;
			acc_q          <= acc_d;
			open_q         <= open_d;
			saw_digit_q    <= saw_digit_d;
			saw_question_q <= saw_question_d;
			saw_other_q    <= saw_other_d;
			sticky_q       <= sticky_d;
			held_year_q    <= held_year_d;
			held_month_q   <= held_month_d;
		end
	end

endmodule

// ----- rtl/dotted_date_string_parser_top.sv -----
// top level of the dotted date string parser
//
// text characters of the form year.month.day arrive on the s_axis channel,
// one per transaction in s_axis_tdata; a nul character ends the text.
// each nul produces one result transaction on m_axis carrying the decoded
// year, month, day and a validity flag; other characters produce none.
// year_limit is written through the apb port at byte address 0; the user
// must do so only while idle, as the block itself does not enforce it.
// path: a character is registered on acceptance and parsed from there; for
// a nul the result is then loaded into the output register (m_axis_tvalid).
// throughput: one character per cycle unless a nul is held, as the
// multiply-by-ten accumulate in the parser is combinational.
// stall: while a result waits in the output register, characters keep
// flowing; only a following nul holds in the input register and drops
// s_axis_tready until the pending result is taken.
// reset: arst_n clears the parse state, empties both registers and sets
// year_limit back to 2047.
module dotted_date_string_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ddsp_pkg::InDataWidth-1:0]    s_axis_tdata,  // [7:0] text_char
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] year_value, [19:16] month_value, [24:20] day_value, [25] text_valid
	output logic [ddsp_pkg::OutDataWidth-1:0]   m_axis_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ddsp_pkg::ApbAddrWidth-1:0]   paddr,
	input  logic [ddsp_pkg::ApbDataWidth-1:0]   pwdata,
	output logic [ddsp_pkg::ApbDataWidth-1:0]   prdata,
	output logic                                pready
);
	import ddsp_pkg::*;

	logic [ValueWidth-1:0] year_limit;
	logic                  valid_s1;
	logic [CharWidth-1:0]  char_s1;
	logic                  advance;
	logic                  result_fire;
	result_t               result;
	logic                  out_valid_q;
	result_t               out_data_q;

	ddsp_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.year_limit (year_limit)
	);

	// a nul only moves on when the output register is free or draining
	assign advance = valid_s1 &&
		!((char_s1 == CharNul) && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata[CharWidth-1:0];
		end
	end

	ddsp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (advance),
		.text_char   (char_s1),
		.year_limit  (year_limit),
		.result_fire (result_fire),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_fire) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDataWidth-ResultWidth){1'b0}}, out_data_q};

`ifndef SYNTHESIS
	a_nul_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (char_s1 == CharNul) |=> m_axis_tvalid)
		else $error("nul transaction did not produce a result");

	a_char_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (char_s1 != CharNul) |=> $stable(out_data_q))
		else $error("result register changed on a non-nul character");

	a_stall_only_on_nul: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && (char_s1 == CharNul) && out_valid_q &&
			!m_axis_tready)
		else $error("input stalled without a pending result");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.month_value <= MonthMax))
		else $error("month value out of range");
`endif

endmodule
